FILE: hdl/sdsh_pkg.sv
// Package for the SPI-mode SD card host sequencer: phase codes, commands, constants.
// No dependencies.
package sdsh_pkg;

    typedef enum logic [5:0] {
        P_IDLE, P_INIT_DELAY, P_INIT_CLOCKS, P_CMD0, P_CMD8, P_R7, P_V2_CMD55, P_V2_ACMD41,
        P_CMD58, P_OCR, P_V1_PROBE55, P_V1_PROBE41, P_V1_CMD55, P_V1_ACMD41, P_CMD1, P_CMD16,
        P_TRAIL_INIT, P_CMD17, P_RD_TOKEN, P_RD_DATA, P_RD_CRC, P_CMD24, P_WR_GAP, P_WR_TOKEN,
        P_WR_DATA, P_WR_CRC, P_WR_RESP, P_WR_BUSY, P_CMD9, P_CSD_TOKEN, P_CSD_DATA, P_CSD_CRC,
        P_TRAIL_OK, P_TRAIL_FAIL
    } t_phase;

    localparam logic [2:0] CMD_INIT  = 3'd0;
    localparam logic [2:0] CMD_READ  = 3'd1;
    localparam logic [2:0] CMD_WRITE = 3'd2;
    localparam logic [2:0] CMD_CAP   = 3'd3;
    localparam logic [2:0] CMD_XDONE = 3'd4;
    localparam logic [2:0] CMD_TICK  = 3'd5;

    localparam logic [2:0] REG_READY_TO = 3'd0;
    localparam logic [2:0] REG_TOKEN_TO = 3'd1;
    localparam logic [2:0] REG_BUSY_TO  = 3'd2;
    localparam logic [2:0] REG_POLL     = 3'd3;
    localparam logic [2:0] REG_RESET_RT = 3'd4;
    localparam logic [2:0] REG_INIT_RT  = 3'd5;

    localparam logic [2:0] KIND_NONE = 3'd0;
    localparam logic [2:0] KIND_MMC  = 3'd1;
    localparam logic [2:0] KIND_SD1  = 3'd2;
    localparam logic [2:0] KIND_SD2  = 3'd3;
    localparam logic [2:0] KIND_SDHC = 3'd4;

    localparam logic [9:0] BLOCK_LAST = 10'd511;
    localparam logic [9:0] CSD_LAST   = 10'd15;

    typedef struct packed {
        logic [15:0] ready_to;
        logic [15:0] token_to;
        logic [15:0] busy_to;
        logic [7:0]  poll_lim;
        logic [7:0]  reset_rt;
        logic [15:0] init_rt;
    } t_cfg;

    typedef struct packed {
        logic        send_valid;
        logic [7:0]  send_byte;
        logic        select_active;
        logic        fast_clock;
        logic        data_valid;
        logic [7:0]  data_byte;
        logic        data_last;
        logic        need_write_byte;
        logic        done_res;
        logic        failed;
        logic [2:0]  card_kind;
        logic [31:0] sector_count;
    } t_result;

    function automatic logic [5:0] cmd_index(input t_phase ph);
        logic [5:0] r;
        unique case (ph)
            P_CMD0:  r = 6'd0;
            P_CMD1:  r = 6'd1;
            P_CMD8:  r = 6'd8;
            P_CMD9:  r = 6'd9;
            P_CMD16: r = 6'd16;
            P_CMD17: r = 6'd17;
            P_CMD24: r = 6'd24;
            P_V2_CMD55, P_V1_PROBE55, P_V1_CMD55: r = 6'd55;
            P_V2_ACMD41, P_V1_PROBE41, P_V1_ACMD41: r = 6'd41;
            P_CMD58: r = 6'd58;
            default: r = 6'd0;
        endcase
        return r;
    endfunction

    function automatic logic is_cmd(input t_phase ph);
        logic r;
        unique case (ph)
            P_CMD0, P_CMD1, P_CMD8, P_CMD9, P_CMD16, P_CMD17, P_CMD24, P_V2_CMD55,
            P_V1_PROBE55, P_V1_CMD55, P_V2_ACMD41, P_V1_PROBE41, P_V1_ACMD41,
            P_CMD58: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

FILE: hdl/sdsh_csd_cap.sv
// CSD capacity decode (versions 1 and 2) from the sixteen stored CSD bytes.
// Depends on sdsh_pkg only through the caller; pure combinational.
module sdsh_csd_cap (
    input  logic [127:0] i_csd,     // byte k at [8k+7:8k]
    output logic [31:0]  o_sectors
);
    logic [7:0]  b0, b5, b6, b7, b8, b9, b10;
    logic [22:0] csize2;
    logic [32:0] cap2;
    logic [4:0]  n;
    logic [12:0] c;
    logic [43:0] wide;

    always_comb begin
        b0  = i_csd[7:0];
        b5  = i_csd[47:40];
        b6  = i_csd[55:48];
        b7  = i_csd[63:56];
        b8  = i_csd[71:64];
        b9  = i_csd[79:72];
        b10 = i_csd[87:80];
        csize2 = {1'b0, b7[5:0], b8, b9} + 23'd1;
        cap2   = {csize2, 10'd0};
        n = 5'(b5[3:0]) + 5'(b10[7]) + 5'({b9[1:0], 1'b0}) + 5'd2;
        c = 13'(b8[7:6]) + {3'd0, b7, 2'd0} + {1'b0, b6[1:0], 10'd0} + 13'd1;
        wide = (n >= 5'd9) ? (44'(c) << (n - 5'd9)) : (44'(c) >> (5'd9 - n));
        if (b0[7:6] == 2'b01)
            o_sectors = cap2[32] ? 32'hFFFF_FFFF : cap2[31:0];
        else
            o_sectors = wide[31:0];
    end
endmodule

FILE: hdl/sd_spi_host_sequencer_unit.sv
// Top level of the SPI-mode SD card host sequencer: config registers, sequencer state,
// output register. Depends on sdsh_pkg and sdsh_csd_cap.
//
//  channel | dir | tdata (low bit up)                              | tuser / tlast
//  s_axis  | in  | sector[31:0] card_byte[39:32] write_byte[47:40] | tuser[2:0] command
//  m_axis  | out | send_valid, send_byte, select_active,           | tlast data_last
//          |     | fast_clock, data_valid, data_byte,              |
//          |     | need_write_byte, done_res, failed, card_kind,   |
//          |     | sector_count (58 of 64 bits)                    |
//  cfg     | in  | i_cfg_we, i_cfg_index, i_cfg_data               | -
// One beat per cycle while the output is not held: each input beat is decoded into at most one result.
// Input is taken whenever the output register is empty or being drained in the same cycle.
// Synchronous active-low reset puts the sequencer idle and loads the register defaults.
module sd_spi_host_sequencer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // sector_number, card_byte, write_byte
    input  logic [2:0]  s_axis_tuser,   // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // send_valid..sector_count as listed above
    output logic        m_axis_tlast,   // data_last
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    sdsh_pkg::t_cfg    r_cfg;
    sdsh_pkg::t_phase  r_phase, n_phase;
    logic [2:0]  r_kind, n_kind;
    logic [9:0]  r_bc, n_bc;
    logic [15:0] r_att, n_att;
    logic [7:0]  r_poll, n_poll;
    logic [15:0] r_ms, n_ms;
    logic [31:0] r_arg, n_arg;
    logic [31:0] r_reply, n_reply;
    logic [7:0]  r_csd [16];
    logic [127:0] csd_flat;
    logic [31:0] csd_sectors;
    logic        r_ovalid;
    sdsh_pkg::t_result r_out, n_out;
    logic        any;
    logic        csd_we;
    logic        take;

    logic [2:0]  in_cmd;
    logic [31:0] in_sector;
    logic [7:0]  in_b, in_wb;

    assign in_cmd    = s_axis_tuser;
    assign in_sector = s_axis_tdata[31:0];
    assign in_b      = s_axis_tdata[39:32];
    assign in_wb     = s_axis_tdata[47:40];

    assign s_axis_tready = !r_ovalid || m_axis_tready;
    assign take = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = {6'd0, r_out.sector_count, r_out.card_kind, r_out.failed,
                           r_out.done_res, r_out.need_write_byte, r_out.data_byte,
                           r_out.data_valid, r_out.fast_clock, r_out.select_active,
                           r_out.send_byte, r_out.send_valid};
    assign m_axis_tlast = r_out.data_last;

    always_comb begin
        for (int k = 0; k < 16; k++) csd_flat[8*k +: 8] = r_csd[k];
    end

    sdsh_csd_cap u_cap (.i_csd(csd_flat), .o_sectors(csd_sectors));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{ready_to: 16'd500, token_to: 16'd200, busy_to: 16'd1000,
                       poll_lim: 8'd200, reset_rt: 8'd20, init_rt: 16'd65534};
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                sdsh_pkg::REG_READY_TO: r_cfg.ready_to <= i_cfg_data;
                sdsh_pkg::REG_TOKEN_TO: r_cfg.token_to <= i_cfg_data;
                sdsh_pkg::REG_BUSY_TO:  r_cfg.busy_to  <= i_cfg_data;
                sdsh_pkg::REG_POLL:     r_cfg.poll_lim <= i_cfg_data[7:0];
                sdsh_pkg::REG_RESET_RT: r_cfg.reset_rt <= i_cfg_data[7:0];
                sdsh_pkg::REG_INIT_RT:  r_cfg.init_rt  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        logic [7:0]  fb;
        logic [5:0]  ci;
        logic        dosel;
        logic        in_init;
        logic [31:0] addr;
        logic        ac;       // run after_cmd
        logic [7:0]  res;
        logic [31:0] rb;
        sdsh_pkg::t_phase sc_ph;  // start_cmd target
        logic        sc;
        logic [31:0] sc_arg;
        logic        sp;          // start_poll
        sdsh_pkg::t_phase sp_ph;
        logic        tr;          // trail
        sdsh_pkg::t_phase tr_ph;
        logic        snd;
        logic [7:0]  sbyte;

        n_phase = r_phase; n_kind = r_kind; n_bc = r_bc; n_att = r_att; n_poll = r_poll;
        n_ms = r_ms; n_arg = r_arg; n_reply = r_reply;
        n_out = '0; any = 1'b0; csd_we = 1'b0;
        ac = 1'b0; res = 8'hFF; rb = 32'd0;
        sc = 1'b0; sc_ph = sdsh_pkg::P_IDLE; sc_arg = 32'd0;
        sp = 1'b0; sp_ph = sdsh_pkg::P_IDLE;
        tr = 1'b0; tr_ph = sdsh_pkg::P_IDLE;
        snd = 1'b0; sbyte = 8'hFF;
        addr = (r_kind == sdsh_pkg::KIND_SDHC) ? in_sector : {in_sector[22:0], 9'd0};
        ci = sdsh_pkg::cmd_index(r_phase);
        unique case (r_bc)
            10'd0: fb = {2'b01, ci};
            10'd1: fb = r_arg[31:24];
            10'd2: fb = r_arg[23:16];
            10'd3: fb = r_arg[15:8];
            10'd4: fb = r_arg[7:0];
            default: fb = (ci == 6'd0) ? 8'h95 : ((ci == 6'd8) ? 8'h87 : 8'h01);
        endcase

        if (in_cmd <= sdsh_pkg::CMD_CAP) begin
            if (r_phase == sdsh_pkg::P_IDLE) begin
                n_reply = 32'd0;
                priority case (in_cmd)
                    sdsh_pkg::CMD_INIT: begin
                        n_kind = sdsh_pkg::KIND_NONE; n_phase = sdsh_pkg::P_INIT_DELAY;
                        n_ms = 16'd0; n_bc = 10'd0;
                    end
                    sdsh_pkg::CMD_READ:  begin sc = 1'b1; sc_ph = sdsh_pkg::P_CMD17; sc_arg = addr; end
                    sdsh_pkg::CMD_WRITE: begin sc = 1'b1; sc_ph = sdsh_pkg::P_CMD24; sc_arg = addr; end
                    default:             begin sc = 1'b1; sc_ph = sdsh_pkg::P_CMD9; end
                endcase
            end
        end else if (in_cmd == sdsh_pkg::CMD_TICK) begin
            if (r_ms != 16'hFFFF) n_ms = r_ms + 16'd1;
            if (r_phase == sdsh_pkg::P_INIT_DELAY && n_ms >= 16'd10) begin
                n_phase = sdsh_pkg::P_INIT_CLOCKS; n_bc = 10'd1; snd = 1'b1;
            end
        end else if (in_cmd == sdsh_pkg::CMD_XDONE && r_phase != sdsh_pkg::P_IDLE &&
                     r_phase != sdsh_pkg::P_INIT_DELAY) begin
            unique case (r_phase)
                sdsh_pkg::P_INIT_CLOCKS: begin
                    if (r_bc < 10'd10) begin n_bc = r_bc + 10'd1; snd = 1'b1; end
                    else begin
                        n_att = 16'(r_cfg.reset_rt); sc = 1'b1; sc_ph = sdsh_pkg::P_CMD0;
                    end
                end
                sdsh_pkg::P_R7, sdsh_pkg::P_OCR: begin
                    rb = {r_reply[23:0], in_b};
                    n_reply = rb; n_bc = r_bc + 10'd1;
                    if (n_bc < 10'd4) snd = 1'b1;
                    else if (r_phase == sdsh_pkg::P_OCR) begin
                        n_kind = rb[30] ? sdsh_pkg::KIND_SDHC : sdsh_pkg::KIND_SD2;
                        tr = 1'b1; tr_ph = sdsh_pkg::P_TRAIL_INIT;
                    end else if (rb[15:8] == 8'h01 && rb[7:0] == 8'hAA) begin
                        n_att = r_cfg.init_rt; sc = 1'b1; sc_ph = sdsh_pkg::P_V2_CMD55;
                    end else begin tr = 1'b1; tr_ph = sdsh_pkg::P_TRAIL_INIT; end
                end
                sdsh_pkg::P_RD_TOKEN, sdsh_pkg::P_CSD_TOKEN: begin
                    if (in_b == 8'hFE) begin
                        sp = 1'b1;
                        sp_ph = (r_phase == sdsh_pkg::P_RD_TOKEN) ? sdsh_pkg::P_RD_DATA
                                                                  : sdsh_pkg::P_CSD_DATA;
                    end else if (r_ms > r_cfg.token_to) begin
                        tr = 1'b1; tr_ph = sdsh_pkg::P_TRAIL_FAIL;
                    end else snd = 1'b1;
                end
                sdsh_pkg::P_RD_DATA: begin
                    n_out.data_valid = 1'b1; n_out.data_byte = in_b;
                    if (r_bc >= sdsh_pkg::BLOCK_LAST) begin
                        n_out.data_last = 1'b1; sp = 1'b1; sp_ph = sdsh_pkg::P_RD_CRC;
                    end else begin n_bc = r_bc + 10'd1; snd = 1'b1; end
                end
                sdsh_pkg::P_CSD_DATA: begin
                    csd_we = 1'b1;
                    if (r_bc >= sdsh_pkg::CSD_LAST) begin sp = 1'b1; sp_ph = sdsh_pkg::P_CSD_CRC; end
                    else begin n_bc = r_bc + 10'd1; snd = 1'b1; end
                end
                sdsh_pkg::P_RD_CRC, sdsh_pkg::P_WR_CRC, sdsh_pkg::P_CSD_CRC: begin
                    if (r_bc == 10'd0) begin n_bc = 10'd1; snd = 1'b1; end
                    else if (r_phase == sdsh_pkg::P_WR_CRC) begin
                        sp = 1'b1; sp_ph = sdsh_pkg::P_WR_RESP;
                    end else begin
                        if (r_phase == sdsh_pkg::P_CSD_CRC) n_reply = csd_sectors;
                        tr = 1'b1; tr_ph = sdsh_pkg::P_TRAIL_OK;
                    end
                end
                sdsh_pkg::P_WR_GAP: begin
                    n_phase = sdsh_pkg::P_WR_TOKEN; snd = 1'b1; sbyte = 8'hFE;
                    n_out.need_write_byte = 1'b1;
                end
                sdsh_pkg::P_WR_TOKEN: begin
                    n_phase = sdsh_pkg::P_WR_DATA; n_bc = 10'd0; snd = 1'b1; sbyte = in_wb;
                    n_out.need_write_byte = 1'b1;
                end
                sdsh_pkg::P_WR_DATA: begin
                    if (r_bc < sdsh_pkg::BLOCK_LAST) begin
                        n_bc = r_bc + 10'd1; snd = 1'b1; sbyte = in_wb;
                        n_out.need_write_byte = n_bc < sdsh_pkg::BLOCK_LAST;
                    end else begin sp = 1'b1; sp_ph = sdsh_pkg::P_WR_CRC; end
                end
                sdsh_pkg::P_WR_RESP: begin
                    if (r_ms > r_cfg.token_to) begin tr = 1'b1; tr_ph = sdsh_pkg::P_TRAIL_FAIL; end
                    else if ((in_b & 8'h11) != 8'h01) snd = 1'b1;
                    else if ((in_b & 8'h1F) == 8'h05) begin sp = 1'b1; sp_ph = sdsh_pkg::P_WR_BUSY; end
                    else begin tr = 1'b1; tr_ph = sdsh_pkg::P_TRAIL_FAIL; end
                end
                sdsh_pkg::P_WR_BUSY: begin
                    if (in_b != 8'd0) begin tr = 1'b1; tr_ph = sdsh_pkg::P_TRAIL_OK; end
                    else if (r_ms > r_cfg.busy_to) begin tr = 1'b1; tr_ph = sdsh_pkg::P_TRAIL_FAIL; end
                    else snd = 1'b1;
                end
                sdsh_pkg::P_TRAIL_INIT, sdsh_pkg::P_TRAIL_OK, sdsh_pkg::P_TRAIL_FAIL: begin
                    any = 1'b1; n_out.done_res = 1'b1;
                    if (r_phase == sdsh_pkg::P_TRAIL_INIT)
                        n_out.failed = (r_kind == sdsh_pkg::KIND_NONE);
                    else if (r_phase == sdsh_pkg::P_TRAIL_FAIL) n_out.failed = 1'b1;
                    else n_out.sector_count = r_reply;
                    n_phase = sdsh_pkg::P_IDLE;
                end
                default: begin
                    if (sdsh_pkg::is_cmd(r_phase)) begin
                        if (r_bc == 10'd0) begin
                            if (in_b == 8'hFF) begin n_bc = 10'd1; snd = 1'b1; sbyte = fb; end
                            else if (r_ms < r_cfg.ready_to) snd = 1'b1;
                            else begin ac = 1'b1; res = 8'hFF; end
                        end else if (r_bc <= 10'd5) begin
                            snd = 1'b1; sbyte = fb; n_bc = r_bc + 10'd1;
                        end else if (r_bc == 10'd6) begin
                            n_poll = r_cfg.poll_lim; n_bc = 10'd7; snd = 1'b1;
                        end else if (!in_b[7] || r_poll == 8'd0) begin
                            ac = 1'b1; res = in_b;
                        end else begin
                            n_poll = r_poll - 8'd1; snd = 1'b1;
                        end
                    end
                end
            endcase
        end

        if (ac) begin
            unique case (r_phase)
                sdsh_pkg::P_CMD0: begin
                    if (res == 8'h01) begin sc = 1'b1; sc_ph = sdsh_pkg::P_CMD8; sc_arg = 32'h1AA; end
                    else if (r_att == 16'd0) begin
                        n_phase = sdsh_pkg::P_IDLE; any = 1'b1;
                        n_out.done_res = 1'b1; n_out.failed = 1'b1;
                    end else begin n_att = r_att - 16'd1; sc = 1'b1; sc_ph = sdsh_pkg::P_CMD0; end
                end
                sdsh_pkg::P_CMD8: begin
                    if (res == 8'h01) begin n_reply = 32'd0; sp = 1'b1; sp_ph = sdsh_pkg::P_R7; end
                    else begin sc = 1'b1; sc_ph = sdsh_pkg::P_V1_PROBE55; end
                end
                sdsh_pkg::P_V2_CMD55: begin
                    sc = 1'b1; sc_ph = sdsh_pkg::P_V2_ACMD41; sc_arg = 32'h4000_0000;
                end
                sdsh_pkg::P_V2_ACMD41: begin
                    if (res == 8'd0) begin sc = 1'b1; sc_ph = sdsh_pkg::P_CMD58; end
                    else if (r_att == 16'd0) begin tr = 1'b1; tr_ph = sdsh_pkg::P_TRAIL_INIT; end
                    else begin n_att = r_att - 16'd1; sc = 1'b1; sc_ph = sdsh_pkg::P_V2_CMD55; end
                end
                sdsh_pkg::P_CMD58: begin
                    if (res == 8'd0) begin n_reply = 32'd0; sp = 1'b1; sp_ph = sdsh_pkg::P_OCR; end
                    else begin tr = 1'b1; tr_ph = sdsh_pkg::P_TRAIL_INIT; end
                end
                sdsh_pkg::P_V1_PROBE55: begin sc = 1'b1; sc_ph = sdsh_pkg::P_V1_PROBE41; end
                sdsh_pkg::P_V1_PROBE41: begin
                    n_att = r_cfg.init_rt; sc = 1'b1;
                    if (res <= 8'd1) begin n_kind = sdsh_pkg::KIND_SD1; sc_ph = sdsh_pkg::P_V1_CMD55; end
                    else begin n_kind = sdsh_pkg::KIND_MMC; sc_ph = sdsh_pkg::P_CMD1; end
                end
                sdsh_pkg::P_V1_CMD55: begin sc = 1'b1; sc_ph = sdsh_pkg::P_V1_ACMD41; end
                sdsh_pkg::P_V1_ACMD41, sdsh_pkg::P_CMD1: begin
                    if (res == 8'd0) begin sc = 1'b1; sc_ph = sdsh_pkg::P_CMD16; sc_arg = 32'd512; end
                    else if (r_att == 16'd0) begin
                        n_kind = sdsh_pkg::KIND_NONE; tr = 1'b1; tr_ph = sdsh_pkg::P_TRAIL_INIT;
                    end else begin
                        n_att = r_att - 16'd1; sc = 1'b1;
                        sc_ph = (r_phase == sdsh_pkg::P_CMD1) ? sdsh_pkg::P_CMD1
                                                              : sdsh_pkg::P_V1_CMD55;
                    end
                end
                sdsh_pkg::P_CMD16: begin
                    if (res != 8'd0) n_kind = sdsh_pkg::KIND_NONE;
                    tr = 1'b1; tr_ph = sdsh_pkg::P_TRAIL_INIT;
                end
                sdsh_pkg::P_CMD17: begin
                    if (res == 8'd0) begin sp = 1'b1; sp_ph = sdsh_pkg::P_RD_TOKEN; end
                    else begin tr = 1'b1; tr_ph = sdsh_pkg::P_TRAIL_FAIL; end
                end
                sdsh_pkg::P_CMD24: begin
                    if (res == 8'd0) begin sp = 1'b1; sp_ph = sdsh_pkg::P_WR_GAP; end
                    else begin tr = 1'b1; tr_ph = sdsh_pkg::P_TRAIL_FAIL; end
                end
                default: begin
                    if (res == 8'd0) begin sp = 1'b1; sp_ph = sdsh_pkg::P_CSD_TOKEN; end
                    else begin tr = 1'b1; tr_ph = sdsh_pkg::P_TRAIL_FAIL; end
                end
            endcase
        end

        if (sc) begin
            n_phase = sc_ph; n_arg = sc_arg; snd = 1'b1;
            if (sc_ph == sdsh_pkg::P_CMD0) begin n_bc = 10'd1; sbyte = 8'h40; end
            else begin n_bc = 10'd0; n_ms = 16'd0; sbyte = 8'hFF; end
        end
        if (sp) begin
            n_phase = sp_ph; n_bc = 10'd0; n_ms = 16'd0; snd = 1'b1; sbyte = 8'hFF;
        end
        if (tr) begin
            n_phase = tr_ph; snd = 1'b1; sbyte = 8'hFF;
        end
        if (snd) begin
            any = 1'b1; n_out.send_valid = 1'b1; n_out.send_byte = sbyte;
        end

        in_init = (n_phase >= sdsh_pkg::P_INIT_DELAY) && (n_phase <= sdsh_pkg::P_TRAIL_INIT);
        dosel = n_phase == sdsh_pkg::P_IDLE || n_phase == sdsh_pkg::P_INIT_DELAY ||
                n_phase == sdsh_pkg::P_INIT_CLOCKS || n_phase == sdsh_pkg::P_TRAIL_INIT ||
                n_phase == sdsh_pkg::P_TRAIL_OK || n_phase == sdsh_pkg::P_TRAIL_FAIL;
        n_out.select_active = !dosel;
        n_out.fast_clock = (n_kind != sdsh_pkg::KIND_NONE) && !in_init;
        n_out.card_kind = n_kind;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= sdsh_pkg::P_IDLE;
            r_kind <= 3'd0; r_bc <= 10'd0; r_att <= 16'd0; r_poll <= 8'd0;
            r_ms <= 16'd0; r_arg <= 32'd0; r_reply <= 32'd0;
            r_ovalid <= 1'b0;
        end else begin
            if (take) begin
                r_phase <= n_phase; r_kind <= n_kind; r_bc <= n_bc; r_att <= n_att;
                r_poll <= n_poll; r_ms <= n_ms; r_arg <= n_arg; r_reply <= n_reply;
            end
            if (take) r_ovalid <= any;
            else if (m_axis_tready) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) r_out <= n_out;
    end

    // CSD bytes arrive in order; every entry is written before capacity is read
    always_ff @(posedge i_clk) begin
        if (take && csd_we) r_csd[r_bc[3:0]] <= in_b;
    end

    a_fail_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (!r_out.failed || r_out.done_res)) else $error("failed without done");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !m_axis_tready) |=> ($stable(r_out) && r_ovalid)) else $error("lost result");
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_out.data_last) |-> r_out.data_valid) else $error("last without data");
endmodule
